@@ rtl/sttt_pkg.sv @@
// ----------------------------------------------------------------------------
// sttt_pkg: shared types and codes of the software timer task table
// Operation and status codes, the per-slot record and the tick unit result.
// ----------------------------------------------------------------------------
package sttt_pkg;

	// table size, tied to the 4-bit slot fields of the ports
	localparam int MAX_TASKS = 16;

	// operation codes
	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_CREATE   = 3'd1;
	localparam logic [2:0] OP_DELETE   = 3'd2;
	localparam logic [2:0] OP_DISPATCH = 3'd3;
	localparam logic [2:0] OP_READ     = 3'd4;
	localparam logic [2:0] OP_CLEAR    = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;
	localparam logic [1:0] ST_NONE    = 2'd3;

	// one slot's record in the slot memory
	typedef struct packed {
		logic        one_shot;
		logic [31:0] period;
		logic [31:0] elapsed;
		logic [31:0] busy;
	} slot_rec_t;

	// tick unit result
	typedef struct packed {
		logic [31:0] elapsed;
		logic [31:0] busy;
		logic        reached;
	} tick_res_t;

endpackage

@@ rtl/sttt_slot_ram.sv @@
// ----------------------------------------------------------------------------
// sttt_slot_ram: slot record memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sttt_slot_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  sttt_pkg::slot_rec_t wdata,
	input  logic [AW-1:0]       raddr,
	output sttt_pkg::slot_rec_t rdata
);

	sttt_pkg::slot_rec_t mem [DEPTH];
	sttt_pkg::slot_rec_t rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/sttt_free_stack.sv @@
// ----------------------------------------------------------------------------
// sttt_free_stack: storage of the free slot stack
// Entries never written read as their reset content, so slot 0 ends on top.
// ----------------------------------------------------------------------------
module sttt_free_stack #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [AW-1:0] rdata
);

	logic [AW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] written_q;
	logic [AW-1:0]    rdata_q;

	// mark entries that hold pushed slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (we) begin
			written_q[waddr] <= 1'b1;
		end
	end

	// write and registered read with reset content fallback
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (written_q[raddr]) begin
			rdata_q <= mem[raddr];
		end else begin
			rdata_q <= AW'(DEPTH - 1) - raddr;
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/sttt_tick_unit.sv @@
// ----------------------------------------------------------------------------
// sttt_tick_unit: shared count and compare unit
// Advances elapsed and busy counts of one slot and checks its period.
// ----------------------------------------------------------------------------
module sttt_tick_unit (
	input  sttt_pkg::slot_rec_t rec,
	output sttt_pkg::tick_res_t res
);

	// advance both counts, compare the wrapped elapsed count
	always_comb begin
		res.elapsed = rec.elapsed + 32'd1;
		res.busy    = rec.busy + 32'd1;
		res.reached = (res.elapsed >= rec.period);
	end

endmodule

@@ rtl/software_timer_task_table.sv @@
// ----------------------------------------------------------------------------
// software_timer_task_table: table of periodic and one-shot software timers
// Sequence: create, read and clear pass S_CREATE or S_SINGLE, then S_FIN
//   loads the result register; rejected items and unused codes go straight
//   to S_FIN. Tick, delete and dispatch walk the run order before S_FIN, with
//   S_ORD_WT and S_ORD_CHK per active slot, and S_EXEC for one it executes.
// Throughput: one item at a time; a new item is taken once the last result
//   of the previous one is loaded into the output register.
// Reset: arst_n clears control state; the table starts empty, all slots free.
// ----------------------------------------------------------------------------
module software_timer_task_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  op,
	input  logic [3:0]  slot,
	input  logic [31:0] period,
	input  logic        one_shot,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [3:0]  task_slot,
	output logic [31:0] busy_ticks,
	output logic        last
);

	localparam int MAX_TASKS = sttt_pkg::MAX_TASKS;
	localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_CREATE, S_SINGLE, S_ORD_WT, S_ORD_CHK, S_EXEC, S_FIN
	} state_t;

	state_t                state_q;
	logic [2:0]            op_q;
	logic [SW-1:0]         sl_q;
	logic [31:0]           period_q;
	logic                  one_shot_q;
	logic [MAX_TASKS-1:0]  in_use_q;
	logic [MAX_TASKS-1:0]  ready_q;
	logic [CW-1:0]         act_q;
	logic [CW-1:0]         free_q;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         wr_q;
	logic [SW-1:0]         cur_q;
	logic                  pend_v_q;
	logic [SW-1:0]         pend_slot_q;
	logic [31:0]           pend_busy_q;
	logic [1:0]            res_st_q;
	logic [3:0]            res_slot_q;
	logic [31:0]           res_busy_q;
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [3:0]            task_slot_q;
	logic [31:0]           busy_q;
	logic                  last_q;

	logic [SW-1:0]         ord_mem [MAX_TASKS];
	logic [SW-1:0]         ord_rd_q;

	logic                  accept;
	logic                  out_free;
	logic [SW-1:0]         sl_in;
	logic                  slot_ok;
	logic                  s_ready;
	logic                  chk_exec;
	logic                  chk_keep;
	logic                  exec_go;
	logic                  exec_keep;
	logic                  adv;
	logic                  keep;
	logic [CW-1:0]         wr_nxt;
	logic [CW-1:0]         idx_nxt;
	logic                  walk_end;
	logic                  ord_we;
	logic [SW-1:0]         ord_waddr;
	logic [SW-1:0]         ord_wdata;
	logic                  ram_we;
	logic [SW-1:0]         ram_waddr;
	logic [SW-1:0]         ram_raddr;
	sttt_pkg::slot_rec_t   ram_wdata;
	sttt_pkg::slot_rec_t   rec;
	sttt_pkg::tick_res_t   tu;
	logic                  stk_we;
	logic [SW-1:0]         stk_wdata;
	logic [SW-1:0]         stk_rd;

	assign accept    = req_valid && (state_q == S_IDLE);
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !rsp_stall;
	assign sl_in     = SW'(slot);
	assign slot_ok   = (32'(slot) < MAX_TASKS) && in_use_q[sl_in];

	// decide what the walk does with the current run order entry
	always_comb begin
		s_ready   = ready_q[ord_rd_q];
		chk_exec  = ((op_q == sttt_pkg::OP_TICK) && !s_ready) ||
			((op_q == sttt_pkg::OP_DISPATCH) && s_ready);
		chk_keep  = ((op_q == sttt_pkg::OP_DELETE) && (ord_rd_q != sl_q)) ||
			((op_q == sttt_pkg::OP_DISPATCH) && !s_ready);
		exec_go   = !((op_q == sttt_pkg::OP_DISPATCH) && pend_v_q && !out_free);
		exec_keep = (op_q == sttt_pkg::OP_DISPATCH) && !rec.one_shot;
		adv       = ((state_q == S_ORD_CHK) && !chk_exec) ||
			((state_q == S_EXEC) && exec_go);
		keep      = (state_q == S_ORD_CHK) ? chk_keep : exec_keep;
		wr_nxt    = wr_q + CW'(adv && keep);
		idx_nxt   = idx_q + CW'(1);
		walk_end  = (idx_nxt == act_q);
	end

	// run order, stack and slot memory write controls
	always_comb begin
		ord_we    = (adv && keep) || (state_q == S_CREATE);
		ord_waddr = (state_q == S_CREATE) ? SW'(act_q) : SW'(wr_q);
		ord_wdata = (state_q == S_CREATE) ? stk_rd :
			((state_q == S_ORD_CHK) ? ord_rd_q : cur_q);

		stk_we    = (accept && (op == sttt_pkg::OP_DELETE) && slot_ok) ||
			((state_q == S_EXEC) && exec_go && (op_q == sttt_pkg::OP_DISPATCH) &&
			rec.one_shot);
		stk_wdata = (state_q == S_IDLE) ? sl_in : cur_q;

		case (state_q)
			S_ORD_CHK: ram_raddr = ord_rd_q;
			S_EXEC:    ram_raddr = cur_q;
			default:   ram_raddr = sl_in;
		endcase

		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = rec;
		case (state_q)
			S_CREATE: begin
				ram_we    = 1'b1;
				ram_waddr = stk_rd;
				ram_wdata = '{one_shot: one_shot_q, period: period_q,
					elapsed: 32'd0, busy: 32'd0};
			end
			S_SINGLE: begin
				ram_we         = (op_q == sttt_pkg::OP_CLEAR);
				ram_waddr      = sl_q;
				ram_wdata.busy = 32'd0;
			end
			S_EXEC: begin
				if (op_q == sttt_pkg::OP_TICK) begin
					ram_we            = 1'b1;
					ram_wdata.elapsed = tu.elapsed;
					ram_wdata.busy    = tu.busy;
				end else begin
					ram_we            = exec_go && exec_keep;
					ram_wdata.elapsed = 32'd0;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// run order memory
	always_ff @(posedge clk) begin
		if (ord_we) begin
			ord_mem[ord_waddr] <= ord_wdata;
		end
		ord_rd_q <= ord_mem[SW'(idx_q)];
	end

	sttt_slot_ram #(
		.DEPTH (MAX_TASKS),
		.AW    (SW)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rec)
	);

	sttt_free_stack #(
		.DEPTH (MAX_TASKS),
		.AW    (SW)
	) u_free_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (stk_we),
		.waddr  (SW'(free_q)),
		.wdata  (stk_wdata),
		.raddr  (SW'(free_q - CW'(1))),
		.rdata  (stk_rd)
	);

	sttt_tick_unit u_tick (
		.rec (rec),
		.res (tu)
	);

	// sequencer, slot flags, counts and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= sttt_pkg::OP_TICK;
			in_use_q    <= '0;
			ready_q     <= '0;
			act_q       <= '0;
			free_q      <= CW'(MAX_TASKS);
			idx_q       <= '0;
			wr_q        <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// drop a beat once taken
			if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q       <= op;
						sl_q       <= sl_in;
						period_q   <= period;
						one_shot_q <= one_shot;
						idx_q      <= '0;
						wr_q       <= '0;
						res_st_q   <= sttt_pkg::ST_OK;
						res_slot_q <= 4'd0;
						res_busy_q <= 32'd0;
						case (op)
							sttt_pkg::OP_TICK, sttt_pkg::OP_DISPATCH: begin
								state_q <= (act_q == '0) ? S_FIN : S_ORD_WT;
							end
							sttt_pkg::OP_CREATE: begin
								if (free_q == '0 || act_q >= CW'(MAX_TASKS)) begin
									res_st_q <= sttt_pkg::ST_FULL;
									state_q  <= S_FIN;
								end else begin
									state_q <= S_CREATE;
								end
							end
							sttt_pkg::OP_DELETE: begin
								res_slot_q <= slot;
								if (!slot_ok) begin
									res_st_q <= sttt_pkg::ST_UNKNOWN;
									state_q  <= S_FIN;
								end else begin
									in_use_q[sl_in] <= 1'b0;
									ready_q[sl_in]  <= 1'b0;
									free_q          <= free_q + CW'(1);
									state_q         <= S_ORD_WT;
								end
							end
							sttt_pkg::OP_READ, sttt_pkg::OP_CLEAR: begin
								res_slot_q <= slot;
								if (!slot_ok) begin
									res_st_q <= sttt_pkg::ST_UNKNOWN;
									state_q  <= S_FIN;
								end else begin
									state_q <= S_SINGLE;
								end
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_CREATE: begin
					in_use_q[stk_rd] <= 1'b1;
					ready_q[stk_rd]  <= 1'b0;
					act_q            <= act_q + CW'(1);
					free_q           <= free_q - CW'(1);
					res_slot_q       <= 4'(stk_rd);
					state_q          <= S_FIN;
				end
				S_SINGLE: begin
					if (op_q == sttt_pkg::OP_READ) begin
						res_busy_q <= rec.busy;
					end
					state_q <= S_FIN;
				end
				S_ORD_WT: begin
					state_q <= S_ORD_CHK;
				end
				S_ORD_CHK: begin
					cur_q <= ord_rd_q;
					if (chk_exec) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (op_q == sttt_pkg::OP_TICK) begin
						if (tu.reached) begin
							ready_q[cur_q] <= 1'b1;
						end
					end else if (exec_go) begin
						// push the held dispatch beat, hold this one
						if (pend_v_q) begin
							out_valid_q <= 1'b1;
							status_q    <= sttt_pkg::ST_OK;
							task_slot_q <= 4'(pend_slot_q);
							busy_q      <= pend_busy_q;
							last_q      <= 1'b0;
						end
						pend_v_q       <= 1'b1;
						pend_slot_q    <= cur_q;
						pend_busy_q    <= rec.busy;
						ready_q[cur_q] <= 1'b0;
						if (rec.one_shot) begin
							in_use_q[cur_q] <= 1'b0;
							free_q          <= free_q + CW'(1);
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						last_q      <= 1'b1;
						if (op_q == sttt_pkg::OP_DISPATCH) begin
							pend_v_q <= 1'b0;
							if (pend_v_q) begin
								status_q    <= sttt_pkg::ST_OK;
								task_slot_q <= 4'(pend_slot_q);
								busy_q      <= pend_busy_q;
							end else begin
								status_q    <= sttt_pkg::ST_NONE;
								task_slot_q <= 4'd0;
								busy_q      <= 32'd0;
							end
						end else begin
							status_q    <= res_st_q;
							task_slot_q <= res_slot_q;
							busy_q      <= res_busy_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// advance the walk, close it at the end of the run order
			if (adv) begin
				idx_q <= idx_nxt;
				wr_q  <= wr_nxt;
				if (walk_end) begin
					if (op_q != sttt_pkg::OP_TICK) begin
						act_q <= wr_nxt;
					end
					state_q <= S_FIN;
				end else begin
					state_q <= S_ORD_WT;
				end
			end
		end
	end

	assign rsp_valid  = out_valid_q;
	assign status     = status_q;
	assign task_slot  = task_slot_q;
	assign busy_ticks = busy_q;
	assign last       = last_q;

endmodule

@@ rtl/sttt_checker.sv @@
// ----------------------------------------------------------------------------
// sttt_checker: port checks of the software timer task table
// Watches the result and request channels; it is bound to the top level.
// ----------------------------------------------------------------------------
module sttt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [1:0]  status,
	input logic [3:0]  task_slot,
	input logic [31:0] busy_ticks,
	input logic        last
);

	// hold a stalled beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) &&
		$stable(task_slot) && $stable(busy_ticks) && $stable(last))
		else $error("stalled result beat changed");

	// an error result is the only beat of its item
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != sttt_pkg::ST_OK |-> last)
		else $error("error result not marked last");

	// full and nothing-ready results carry no slot or count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == sttt_pkg::ST_FULL || status == sttt_pkg::ST_NONE)
		|-> task_slot == 4'd0 && busy_ticks == 32'd0)
		else $error("full or none result carries data");

	// unknown slot reports no count
	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == sttt_pkg::ST_UNKNOWN |-> busy_ticks == 32'd0)
		else $error("unknown slot result carries a count");

	// stall the request side in the cycle after a beat is taken
	a_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken without a following stall");

endmodule

bind software_timer_task_table sttt_checker u_sttt_checker (.*);

@@ tb/sv/software_timer_task_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// software_timer_task_table_tb: self-checking bench for the timer task table
// Drives tick, create, delete, dispatch, read and clear operations with
// random bursts and response stalls, predicts every result beat from a
// model of the slot table, and compares the beats field by field in order.
// ----------------------------------------------------------------------------
module software_timer_task_table_tb;

	localparam int SLOTS = 16;

	typedef struct {
		logic [1:0]  status;
		logic [3:0]  task_slot;
		logic [31:0] busy_ticks;
		logic        last;
	} beat_t;

	// report a mismatch and count it
	int error_count = 0;
	task automatic report(input string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// timer table prediction and expected beat store
	class timer_scoreboard;
		bit          in_use[SLOTS];
		bit          ready[SLOTS];
		bit [31:0]   elapsed[SLOTS];
		bit [31:0]   per[SLOTS];
		bit          oneshot[SLOTS];
		bit [31:0]   busy[SLOTS];
		int          order[$];
		int          free_slots[$];
		beat_t       pending[$];

		function void clear_table();
			order.delete();
			free_slots.delete();
			pending.delete();
			for (int i = 0; i < SLOTS; i++) begin
				in_use[i] = 0;
				ready[i] = 0;
				free_slots.push_back(SLOTS - 1 - i);
			end
		endfunction

		function void push_beat(logic [1:0] st, logic [3:0] sl, logic [31:0] b, logic l);
			beat_t e;
			e.status = st;
			e.task_slot = sl;
			e.busy_ticks = b;
			e.last = l;
			pending.push_back(e);
		endfunction

		function void drop_slot(int s);
			foreach (order[i]) begin
				if (order[i] == s) begin
					order.delete(i);
					break;
				end
			end
			in_use[s] = 0;
			ready[s] = 0;
			free_slots.push_back(s);
		endfunction

		// note an accepted request and queue its expected beats
		function void note_request(logic [2:0] op, logic [3:0] sl, logic [31:0] p, logic os);
			int s;
			int n;
			int i;
			case (op)
				sttt_pkg::OP_TICK: begin
					foreach (order[k]) begin
						s = order[k];
						if (!ready[s]) begin
							elapsed[s]++;
							busy[s]++;
							if (elapsed[s] >= per[s])
								ready[s] = 1;
						end
					end
					push_beat(sttt_pkg::ST_OK, 4'd0, 32'd0, 1'b1);
				end
				sttt_pkg::OP_CREATE: begin
					if (free_slots.size() == 0) begin
						push_beat(sttt_pkg::ST_FULL, 4'd0, 32'd0, 1'b1);
					end else begin
						s = free_slots.pop_back();
						in_use[s] = 1;
						ready[s] = 0;
						elapsed[s] = 0;
						per[s] = p;
						oneshot[s] = os;
						busy[s] = 0;
						order.push_back(s);
						push_beat(sttt_pkg::ST_OK, 4'(s), 32'd0, 1'b1);
					end
				end
				sttt_pkg::OP_DELETE: begin
					if (!in_use[sl]) begin
						push_beat(sttt_pkg::ST_UNKNOWN, sl, 32'd0, 1'b1);
					end else begin
						drop_slot(int'(sl));
						push_beat(sttt_pkg::ST_OK, sl, 32'd0, 1'b1);
					end
				end
				sttt_pkg::OP_DISPATCH: begin
					n = 0;
					i = 0;
					while (i < order.size()) begin
						s = order[i];
						if (ready[s]) begin
							push_beat(sttt_pkg::ST_OK, 4'(s), busy[s], 1'b0);
							n++;
							if (oneshot[s]) begin
								drop_slot(s);
								continue;
							end
							ready[s] = 0;
							elapsed[s] = 0;
						end
						i++;
					end
					if (n == 0)
						push_beat(sttt_pkg::ST_NONE, 4'd0, 32'd0, 1'b1);
					else
						pending[pending.size() - 1].last = 1;
				end
				sttt_pkg::OP_READ: begin
					if (!in_use[sl])
						push_beat(sttt_pkg::ST_UNKNOWN, sl, 32'd0, 1'b1);
					else
						push_beat(sttt_pkg::ST_OK, sl, busy[sl], 1'b1);
				end
				sttt_pkg::OP_CLEAR: begin
					if (!in_use[sl]) begin
						push_beat(sttt_pkg::ST_UNKNOWN, sl, 32'd0, 1'b1);
					end else begin
						busy[sl] = 0;
						push_beat(sttt_pkg::ST_OK, sl, 32'd0, 1'b1);
					end
				end
				default: push_beat(sttt_pkg::ST_OK, 4'd0, 32'd0, 1'b1);
			endcase
		endfunction

		// check one result beat against the oldest expectation
		task check_beat(beat_t got);
			beat_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected beat status %0d slot %0d", got.status,
					got.task_slot));
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status)
				report($sformatf("status %0d, want %0d", got.status, e.status));
			if (got.task_slot !== e.task_slot)
				report($sformatf("task_slot %0d, want %0d", got.task_slot, e.task_slot));
			if (got.busy_ticks !== e.busy_ticks)
				report($sformatf("busy_ticks %0d, want %0d", got.busy_ticks,
					e.busy_ticks));
			if (got.last !== e.last)
				report($sformatf("last %0d, want %0d", got.last, e.last));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        req_valid = 0;
	logic        req_stall;
	logic [2:0]  op = 0;
	logic [3:0]  slot = 0;
	logic [31:0] period = 0;
	logic        one_shot = 0;
	logic        rsp_valid;
	logic        rsp_stall = 0;
	logic [1:0]  status;
	logic [3:0]  task_slot;
	logic [31:0] busy_ticks;
	logic        last;

	timer_scoreboard table_sb = new();
	bit hold_off = 0;
	bit rsp_random = 1;

	software_timer_task_table u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.op(op), .slot(slot), .period(period), .one_shot(one_shot),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .task_slot(task_slot), .busy_ticks(busy_ticks), .last(last)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// drive one request beat and hold it until accepted
	task automatic send(input logic [2:0] o, input logic [3:0] s,
			input logic [31:0] p, input logic os);
		req_valid <= 1;
		op <= o;
		slot <= s;
		period <= p;
		one_shot <= os;
		do @(posedge clk); while (req_stall);
		table_sb.note_request(o, s, p, os);
	endtask

	// insert an idle gap on the request side
	task automatic idle(input int n);
		if (n > 0) begin
			req_valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	// pick a random slot, mostly one in use
	function automatic logic [3:0] pick_slot();
		if (table_sb.order.size() > 0 && $urandom_range(0, 3) != 0)
			return 4'(table_sb.order[$urandom_range(0, table_sb.order.size() - 1)]);
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic logic [31:0] pick_period();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 6);
		endcase
	endfunction

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			send(sttt_pkg::OP_TICK, 4'($urandom), $urandom, 1'($urandom));
		else if (r < 55)
			send(sttt_pkg::OP_CREATE, 4'($urandom), pick_period(), 1'($urandom));
		else if (r < 65)
			send(sttt_pkg::OP_DELETE, pick_slot(), $urandom, 1'($urandom));
		else if (r < 82)
			send(sttt_pkg::OP_DISPATCH, 4'($urandom), $urandom, 1'($urandom));
		else if (r < 91)
			send(sttt_pkg::OP_READ, pick_slot(), $urandom, 1'($urandom));
		else if (r < 97)
			send(sttt_pkg::OP_CLEAR, pick_slot(), $urandom, 1'($urandom));
		else
			send(3'($urandom_range(6, 7)), 4'($urandom), $urandom, 1'($urandom));
	endtask

	// check result beats as they are accepted
	always @(posedge clk) begin
		beat_t got;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got.status = status;
			got.task_slot = task_slot;
			got.busy_ticks = busy_ticks;
			got.last = last;
			table_sb.check_beat(got);
		end
	end

	// stall the response side on its own pattern
	always @(posedge clk) begin
		if (hold_off)
			rsp_stall <= 1;
		else if (rsp_random)
			rsp_stall <= ($urandom_range(0, 3) == 0);
		else
			rsp_stall <= 0;
	end

	// main stimulus
	initial begin
		int burst;
		int wait_cycles;
		table_sb.clear_table();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table, full table, extremes and special cases
		send(sttt_pkg::OP_DISPATCH, 0, 0, 0);
		send(sttt_pkg::OP_TICK, 0, 0, 0);
		send(sttt_pkg::OP_READ, 4'hF, 0, 0);
		send(sttt_pkg::OP_DELETE, 0, 0, 0);
		send(sttt_pkg::OP_CLEAR, 4'h5, 0, 0);
		send(sttt_pkg::OP_CREATE, 0, 0, 1);
		send(sttt_pkg::OP_CREATE, 4'hF, 32'hFFFF_FFFF, 0);
		send(sttt_pkg::OP_CREATE, 0, 2, 0);
		send(sttt_pkg::OP_TICK, 4'hF, 32'hFFFF_FFFF, 1);
		send(sttt_pkg::OP_DISPATCH, 0, 0, 0);
		send(sttt_pkg::OP_TICK, 0, 0, 0);
		send(sttt_pkg::OP_TICK, 0, 0, 0);
		send(sttt_pkg::OP_READ, 1, 0, 0);
		send(sttt_pkg::OP_DISPATCH, 0, 0, 0);
		send(sttt_pkg::OP_CLEAR, 2, 0, 0);
		send(3'd6, 4'hA, 32'h5555_5555, 1);
		send(3'd7, 4'h5, 32'hAAAA_AAAA, 0);
		for (int i = 0; i < 15; i++)
			send(sttt_pkg::OP_CREATE, 0, 32'(i[0]), 1);
		send(sttt_pkg::OP_TICK, 0, 0, 0);
		send(sttt_pkg::OP_DISPATCH, 0, 0, 0);
		send(sttt_pkg::OP_DELETE, 1, 0, 0);
		send(sttt_pkg::OP_DELETE, 1, 0, 0);
		idle(1);

		// long response hold-off while requests keep coming
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			repeat (30) random_item();
		join

		// random bursts, with a stretch of no stalls in the middle
		for (int n = 0; n < 340; ) begin
			burst = $urandom_range(1, 20);
			rsp_random = !(n > 150 && n < 220);
			for (int k = 0; k < burst; k++) begin
				random_item();
				n++;
			end
			idle($urandom_range(0, 5));
		end
		req_valid <= 0;
		rsp_random = 1;

		// drain
		wait_cycles = 0;
		while (table_sb.pending.size() > 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (100) @(posedge clk);
		if (error_count == 0 && table_sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
